// ===== sv/rlcd_pkg.sv =====
// shared types, constants and codes of the rgb led chain driver
`timescale 1ns / 1ps

package rlcd_pkg;

  localparam int NUM_PIXELS     = 8;
  localparam int PIX_AW         = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int TICK_W         = 10;
  localparam int BIT_W          = 5;
  localparam int BITS_PER_PIXEL = 24;
  localparam int CFG_IDX_W      = 2;

  localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 10'd20;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 10'd40;
  localparam logic [TICK_W-1:0] BIT_PERIOD_RST = 10'd62;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_BRIGHT = 3'd2,
    OP_READ   = 3'd3,
    OP_START  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH  = 2'd0,
    CFG_ONE_HIGH   = 2'd1,
    CFG_BIT_PERIOD = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_MUL_R,
    S_MUL_G,
    S_MUL_B,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] pixel_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] brightness_in;
  } in_item_t;

  typedef struct packed {
    logic       pin_level;
    logic       busy_res;
    logic [1:0] status;
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic [7:0] read_brightness;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic fetch;
    logic mul_r;
    logic mul_g;
    logic mul_b;
    logic res_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       sending;
    logic       tick_load;
  } dp_stat_t;

endpackage

// ===== sv/rlcd_ctrl.sv =====
// sequencing state machine of the rgb led chain driver
`timescale 1ns / 1ps

module rlcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rlcd_pkg::dp_stat_t stat_i,
  output rlcd_pkg::ctl_cmd_t cmd_o
);
  import rlcd_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (stat_i.op)
          OP_TICK:  state_d = stat_i.tick_load ? S_FETCH : S_DONE;
          OP_START: state_d = stat_i.sending ? S_DONE : S_FETCH;
          default:  state_d = S_DONE;
        endcase
      end
      S_FETCH: state_d = S_MUL_R;
      S_MUL_R: state_d = S_MUL_G;
      S_MUL_G: state_d = S_MUL_B;
      S_MUL_B: state_d = S_DONE;
      S_DONE: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.fetch    = (state_q == S_FETCH);
    cmd_o.mul_r    = (state_q == S_MUL_R);
    cmd_o.mul_g    = (state_q == S_MUL_G);
    cmd_o.mul_b    = (state_q == S_MUL_B);
    cmd_o.res_load = (state_q == S_DONE) && slot_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded while a result still waits");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted transaction not executed next cycle");

  a_scale_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL_B) |=> (state_q == S_DONE))
    else $error("pixel scaling did not end in result state");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> in_ready_o)
    else $error("block not ready after delivering a result");

endmodule

// ===== sv/rlcd_dpath.sv =====
// pixel store, frame counters, colour scaling and result register
`timescale 1ns / 1ps

module rlcd_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rlcd_pkg::in_item_t                in_data_i,
  output rlcd_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [rlcd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rlcd_pkg::TICK_W-1:0]       cfg_wdata_i,
  input  rlcd_pkg::ctl_cmd_t                cmd_i,
  output rlcd_pkg::dp_stat_t                stat_o
);
  import rlcd_pkg::*;

  // held transaction
  in_item_t item_q;

  // pixel store: colour {r,g,b} and brightness kept apart so brightness writes alone
  logic [23:0] col_mem [NUM_PIXELS];
  logic [7:0]  br_mem  [NUM_PIXELS];
  logic [NUM_PIXELS-1:0] col_vld_q, col_vld_d;
  logic [NUM_PIXELS-1:0] br_vld_q, br_vld_d;
  logic [23:0] col_rd_q;
  logic [7:0]  br_rd_q;
  logic        col_rd_vld_q, br_rd_vld_q;
  logic [23:0] col_rd;
  logic [7:0]  br_rd;

  // frame state
  logic [PIX_AW-1:0]   frame_q, frame_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic                sending_q, sending_d;
  logic [23:0]         scaled_q, scaled_d;
  logic [1:0]          status_q, status_d;

  logic [TICK_W-1:0]   zero_high_q, one_high_q, period_q;

  logic                in_range, is_read, is_write, is_bright;
  logic [PIX_AW-1:0]   item_addr, rd_addr;
  logic                rd_en, col_we, br_we;
  logic [TICK_W:0]     tick_nxt;
  logic                tick_wrap, bit_wrap, last_pix;
  logic [7:0]          mul_a;
  logic [15:0]         prod;
  logic                cur_bit, pin;
  logic [TICK_W-1:0]   high_ticks;
  out_item_t           res_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  assign in_range  = ({1'b0, item_q.pixel_index} < 9'(NUM_PIXELS));
  assign item_addr = item_q.pixel_index[PIX_AW-1:0];
  assign is_read   = (item_q.opcode == OP_READ);
  assign is_write  = (item_q.opcode == OP_WRITE);
  assign is_bright = (item_q.opcode == OP_BRIGHT);

  assign col_we  = cmd_i.exec && is_write && in_range;
  assign br_we   = cmd_i.exec && (is_write || is_bright) && in_range;
  assign rd_en   = cmd_i.fetch || (cmd_i.exec && is_read && in_range);
  assign rd_addr = cmd_i.fetch ? frame_q : item_addr;

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[item_addr] <= {item_q.red_in, item_q.green_in, item_q.blue_in};
    if (br_we)  br_mem[item_addr]  <= item_q.brightness_in;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      col_rd_q <= col_mem[rd_addr];
      br_rd_q  <= br_mem[rd_addr];
    end
  end

  always_comb begin
    col_vld_d = col_vld_q;
    br_vld_d  = br_vld_q;
    if (col_we) col_vld_d[item_addr] = 1'b1;
    if (br_we)  br_vld_d[item_addr]  = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vld_q    <= '0;
      br_vld_q     <= '0;
      col_rd_vld_q <= 1'b0;
      br_rd_vld_q  <= 1'b0;
    end else begin
      col_vld_q <= col_vld_d;
      br_vld_q  <= br_vld_d;
      if (rd_en) begin
        col_rd_vld_q <= col_vld_q[rd_addr];
        br_rd_vld_q  <= br_vld_q[rd_addr];
      end
    end
  end

  // entries never written read as zero
  assign col_rd = col_rd_vld_q ? col_rd_q : 24'd0;
  assign br_rd  = br_rd_vld_q ? br_rd_q : 8'd0;

  // waveform counters
  assign tick_nxt  = {1'b0, tick_q} + {{TICK_W{1'b0}}, 1'b1};
  assign tick_wrap = (tick_nxt >= {1'b0, period_q});
  assign bit_wrap  = (bit_q == BIT_W'(BITS_PER_PIXEL - 1));
  assign last_pix  = (frame_q >= PIX_AW'(NUM_PIXELS - 1));

  // one shared 8x8 multiplier, one colour per cycle
  always_comb begin
    mul_a = col_rd[7:0];
    if (cmd_i.mul_r) begin
      mul_a = col_rd[23:16];
    end else if (cmd_i.mul_g) begin
      mul_a = col_rd[15:8];
    end
  end
  assign prod = mul_a * br_rd;

  always_comb begin
    frame_d   = frame_q;
    bit_d     = bit_q;
    tick_d    = tick_q;
    sending_d = sending_q;
    scaled_d  = scaled_q;
    status_d  = status_q;
    if (cmd_i.exec) begin
      status_d = ST_OK;
      case (item_q.opcode)
        OP_TICK: begin
          if (sending_q) begin
            if (!tick_wrap) begin
              tick_d = tick_nxt[TICK_W-1:0];
            end else begin
              tick_d = '0;
              if (!bit_wrap) begin
                bit_d = bit_q + BIT_W'(1);
              end else begin
                bit_d = '0;
                if (last_pix) begin
                  sending_d = 1'b0;
                  frame_d   = '0;
                end else begin
                  frame_d = frame_q + PIX_AW'(1);
                end
              end
            end
          end
        end
        OP_WRITE, OP_BRIGHT, OP_READ: begin
          if (!in_range) status_d = ST_RANGE;
        end
        OP_START: begin
          if (sending_q) begin
            status_d = ST_BUSY;
          end else begin
            sending_d = 1'b1;
            frame_d   = '0;
            bit_d     = '0;
            tick_d    = '0;
          end
        end
        default: status_d = ST_OK;
      endcase
    end
    // line order is green, red, blue
    if (cmd_i.mul_r) scaled_d[15:8]  = prod[15:8];
    if (cmd_i.mul_g) scaled_d[23:16] = prod[15:8];
    if (cmd_i.mul_b) scaled_d[7:0]   = prod[15:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q   <= '0;
      bit_q     <= '0;
      tick_q    <= '0;
      sending_q <= 1'b0;
      scaled_q  <= '0;
      status_q  <= ST_OK;
    end else begin
      frame_q   <= frame_d;
      bit_q     <= bit_d;
      tick_q    <= tick_d;
      sending_q <= sending_d;
      scaled_q  <= scaled_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q <= ZERO_HIGH_RST;
      one_high_q  <= ONE_HIGH_RST;
      period_q    <= BIT_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ZERO_HIGH:  zero_high_q <= cfg_wdata_i;
        CFG_ONE_HIGH:   one_high_q  <= cfg_wdata_i;
        CFG_BIT_PERIOD: period_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // msb first within the 24 bit word
  assign cur_bit    = scaled_q[BIT_W'(BITS_PER_PIXEL - 1) - bit_q];
  assign high_ticks = cur_bit ? one_high_q : zero_high_q;
  assign pin        = sending_q && (tick_q < high_ticks);

  always_comb begin
    res_d                 = '0;
    res_d.pin_level       = pin;
    res_d.busy_res        = sending_q;
    res_d.status          = status_q;
    if (is_read && in_range) begin
      res_d.read_red        = col_rd[23:16];
      res_d.read_green      = col_rd[15:8];
      res_d.read_blue       = col_rd[7:0];
      res_d.read_brightness = br_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) out_data_o <= res_d;
  end

  assign stat_o.op        = item_q.opcode;
  assign stat_o.sending   = sending_q;
  assign stat_o.tick_load = sending_q && tick_wrap && bit_wrap && !last_pix;

endmodule

// ===== sv/rgb_led_chain_driver_unit.sv =====
// top level of the rgb led chain driver: controller plus datapath
`timescale 1ns / 1ps

// Serial RGB LED chain driver. Each transaction is a command (tick, write pixel,
// set brightness, read pixel, start frame) and gives one result with the line
// level after it. A transaction is accepted when idle, executed in the execute
// state and its result registered in the done state; no new one is accepted
// before then. A tick that moves the frame to the next pixel, and a start that
// is not rejected, also pass through the fetch and three scaling states, since
// the next pixel is read from the single-port pixel store and its three colours
// are scaled one after another on one shared 8x8 multiplier. The next transaction
// is accepted in the cycle after the result is registered, whether or not that
// result has been taken yet; it then waits for the output register to free up.
// The pixel store reads as zero after reset with no clearing pass. The user must
// write the tick count registers only between transactions; the block does not enforce it.
module rgb_led_chain_driver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rlcd_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rlcd_pkg::out_item_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [rlcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rlcd_pkg::TICK_W-1:0]    cfg_wdata_i
);
  import rlcd_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  rlcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rlcd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
